// File: rtl/gte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gte_pkg: shared constants and types of the graph traversal engine
// Node count, mode codes and the request struct for the adjacency memory.
// ----------------------------------------------------------------------------
package gte_pkg;

    localparam int Nodes = 64;
    localparam int NodeW = 6;
    localparam int PtrW  = 7;

    typedef enum logic [1:0] {
        MODE_BFS  = 2'd0,
        MODE_DFS  = 2'd1,
        MODE_REC  = 2'd2,
        MODE_REC3 = 2'd3
    } t_mode;

    localparam logic FUNC_EDGE  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    // adjacency memory request: one read or one full-row write a cycle
    typedef struct packed {
        logic             wr;
        logic [NodeW-1:0] addr;
        logic [Nodes-1:0] wmask;
    } t_adj_req;

    // lowest set bit of a row (row assumed non-zero)
    function automatic logic [NodeW-1:0] lowest_bit(input logic [Nodes-1:0] v);
        logic [NodeW-1:0] r;
        r = NodeW'(Nodes - 1);
        for (int i = Nodes - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = NodeW'(i);
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/gte_adj_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gte_adj_mem: adjacency row store
// Synchronous memory of rows with a full-row write port; valid bits per row give
// the all-zero reset without a clearing pass. Read data registered.
// ----------------------------------------------------------------------------
module gte_adj_mem (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gte_pkg::t_adj_req                   i_req,
    input  logic                                i_rd,
    output logic [gte_pkg::Nodes-1:0]           o_rdata
);

    logic [gte_pkg::Nodes-1:0] r_mem [gte_pkg::Nodes];
    logic [gte_pkg::Nodes-1:0] r_vld;
    logic [gte_pkg::Nodes-1:0] r_rdata;
    logic                      r_rvld;

    // row valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.wr) begin
            r_vld[i_req.addr] <= 1'b1;
        end
    end

    // write full new row (caller supplies old | new), registered read
    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_req.addr] <= i_req.wmask;
        end
        if (i_rd) begin
            r_rdata <= r_mem[i_req.addr];
            r_rvld  <= r_vld[i_req.addr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

// File: rtl/graph_traversal_engine.sv
`timescale 1ns / 1ps
// Graph traversal engine. An edge item is two row read-modify-writes in the
// adjacency memory. A start item checks the start row, then steps through
// pop, pending read, row read and row check for every vertex taken from the
// pending memory, then through the push step for each fresh neighbor before
// leaving it; the recursive order repeats those steps for every backtrack.
// The single read ports of the adjacency memory and the pending memory set
// the pace. Results leave through an output register; the walk stalls while
// it is full.
// ----------------------------------------------------------------------------
// graph_traversal_engine: BFS / DFS / recursive-order walker over an adjacency bit matrix
// Sequencer around the adjacency memory and a pending queue/stack memory.
// ----------------------------------------------------------------------------
module graph_traversal_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [1:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_func,
    input  logic [gte_pkg::NodeW-1:0]     i_node_a,
    input  logic [gte_pkg::NodeW-1:0]     i_node_b,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [gte_pkg::NodeW-1:0]     o_visited_node,
    output logic                          o_last,
    output logic                          o_status
);

    typedef enum logic [3:0] {
        S_IDLE, S_E_RDA, S_E_WRA, S_E_RDB, S_E_WRB,
        S_S_RD, S_S_CHK, S_POP, S_POP_W, S_ROW_RD, S_ROW_W, S_PUSH, S_FLUSH
    } t_state;

    localparam int Nodes = gte_pkg::Nodes;
    localparam int NodeW = gte_pkg::NodeW;
    localparam int PtrW  = gte_pkg::PtrW;

    t_state               r_state;
    logic [1:0]           r_mode;
    logic [NodeW-1:0]     r_a, r_b, r_cur;
    logic [Nodes-1:0]     r_vis, r_fresh;
    logic [PtrW-1:0]      r_head, r_tail;
    logic [6:0]           r_cnt;
    logic                 r_pend_v;     // a result held back until next is known
    logic [NodeW-1:0]     r_pend_n;
    logic                 r_ov;
    logic [NodeW-1:0]     r_on;
    logic                 r_ol, r_os;
    logic [NodeW-1:0]     r_pmem [Nodes];
    logic [NodeW-1:0]     r_prd;

    gte_pkg::t_adj_req    adj_req;
    logic                 adj_rd;
    logic [Nodes-1:0]     adj_row, fresh_c;
    logic                 mode_bfs, mode_rec, out_free, out_load;
    logic                 pm_wr, pm_rd;
    logic [NodeW-1:0]     pm_waddr, pm_raddr, pm_wdata;

    gte_adj_mem u_adj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (adj_req),
        .i_rd    (adj_rd),
        .o_rdata (adj_row)
    );

    assign mode_bfs = (r_mode == gte_pkg::MODE_BFS);
    assign mode_rec = (r_mode == gte_pkg::MODE_REC) || (r_mode == gte_pkg::MODE_REC3);
    assign out_free = !r_ov || i_ready;
    assign fresh_c  = adj_row & ~r_vis;

    // output register takes a new result this cycle
    assign out_load = out_free && (
        (r_state == S_S_CHK && adj_row == '0)
        || (r_state == S_POP_W && r_pend_v && !mode_rec)
        || (r_state == S_PUSH && mode_rec && r_pend_v && r_fresh != '0
            && !r_tail[PtrW-1])
        || (r_state == S_FLUSH));

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {30'd0, r_mode} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= gte_pkg::MODE_BFS;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_mode <= pwdata[1:0];
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_ov;
    assign o_visited_node = r_on;
    assign o_last         = r_ol;
    assign o_status       = r_os;

    // memory request decode
    always_comb begin
        adj_req = '0;
        adj_rd  = 1'b0;
        pm_wr   = 1'b0;
        pm_rd   = 1'b0;
        pm_waddr = r_tail[NodeW-1:0];
        pm_wdata = gte_pkg::lowest_bit(r_fresh);
        pm_raddr = mode_bfs ? r_head[NodeW-1:0] : NodeW'(r_tail - 1'b1);
        unique case (r_state)
            S_IDLE: begin
                adj_req.addr = i_node_a;
                adj_rd = i_valid;
            end
            S_E_WRA: begin
                adj_req.wr = 1'b1;
                adj_req.addr = r_a;
                adj_req.wmask = adj_row | (Nodes'(1) << r_b);
            end
            S_E_RDB: begin
                adj_req.addr = r_b;
                adj_rd = 1'b1;
            end
            S_E_WRB: begin
                adj_req.wr = 1'b1;
                adj_req.addr = r_b;
                adj_req.wmask = adj_row | (Nodes'(1) << r_a);
            end
            S_S_CHK: begin
                pm_wr = 1'b1;
                pm_waddr = '0;
                pm_wdata = r_a;
            end
            S_POP: pm_rd = 1'b1;
            S_ROW_RD: begin
                adj_req.addr = r_cur;
                adj_rd = 1'b1;
            end
            S_PUSH: pm_wr = (r_fresh != '0) && !r_tail[PtrW-1];
            default: ;
        endcase
    end

    // pending memory
    always_ff @(posedge i_clk) begin
        if (pm_wr) begin
            r_pmem[pm_waddr] <= pm_wdata;
        end
        if (pm_rd) begin
            r_prd <= r_pmem[pm_raddr];
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend_v <= 1'b0;
            r_head   <= '0;
            r_tail   <= '0;
            r_cnt    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_a <= i_node_a;
                        r_b <= i_node_b;
                        r_state <= (i_func == gte_pkg::FUNC_EDGE) ? S_E_RDA : S_S_CHK;
                    end
                end
                S_E_RDA: r_state <= S_E_WRA;   // row a arrives
                S_E_WRA: r_state <= S_E_RDB;
                S_E_RDB: r_state <= S_E_WRB;
                S_E_WRB: r_state <= S_IDLE;
                S_S_CHK: begin
                    if (adj_row == '0) begin
                        if (out_free) begin
                            r_on <= r_a;
                            r_ol <= 1'b1;
                            r_os <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_vis  <= Nodes'(1) << r_a;
                        r_head <= '0;
                        r_tail <= PtrW'(1);
                        r_pend_v <= mode_rec;
                        r_pend_n <= r_a;
                        r_cnt  <= mode_rec ? 7'd1 : 7'd0;
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    // pending empty or result budget spent: finish
                    if ((mode_bfs ? (r_head == r_tail) : (r_tail == '0))
                            || r_cnt == 7'd64) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_state <= S_POP_W;
                    end
                end
                S_POP_W: begin
                    // recursive order only peeks at the top here
                    if (mode_rec || !r_pend_v || out_free) begin
                        r_cur <= r_prd;
                        if (r_pend_v && !mode_rec) begin
                            r_on <= r_pend_n;
                            r_ol <= 1'b0;
                            r_os <= 1'b0;
                        end
                        if (mode_rec) begin
                            r_pend_v <= r_pend_v;
                        end else begin
                            r_pend_v <= 1'b1;
                            r_pend_n <= r_prd;
                            r_cnt <= r_cnt + 7'd1;
                            if (mode_bfs) begin
                                r_head <= r_head + 1'b1;
                            end else begin
                                r_tail <= r_tail - 1'b1;
                            end
                        end
                        r_state <= S_ROW_RD;
                    end
                end
                S_ROW_RD: r_state <= S_ROW_W;
                S_ROW_W: begin
                    if (mode_rec) begin
                        if (fresh_c == '0 || r_tail[PtrW-1]) begin
                            r_tail <= r_tail - 1'b1;
                            r_state <= S_POP;
                        end else begin
                            r_fresh <= Nodes'(1) << gte_pkg::lowest_bit(fresh_c);
                            r_state <= S_PUSH;
                        end
                    end else begin
                        r_fresh <= fresh_c;
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    // one fresh neighbor per cycle, lowest first; REC waits on output
                    if (r_fresh != '0 && !r_tail[PtrW-1]) begin
                        if (mode_rec) begin
                            if (out_free || !r_pend_v) begin
                                r_vis[gte_pkg::lowest_bit(r_fresh)] <= 1'b1;
                                r_tail <= r_tail + 1'b1;
                                r_fresh <= '0;
                                if (r_pend_v) begin
                                    r_on <= r_pend_n;
                                    r_ol <= 1'b0;
                                    r_os <= 1'b0;
                                end
                                r_pend_v <= 1'b1;
                                r_pend_n <= gte_pkg::lowest_bit(r_fresh);
                                r_cnt <= r_cnt + 7'd1;
                                r_state <= S_POP;
                            end
                        end else begin
                            r_vis[gte_pkg::lowest_bit(r_fresh)] <= 1'b1;
                            r_tail <= r_tail + 1'b1;
                            r_fresh <= r_fresh & (r_fresh - 1'b1);
                        end
                    end else begin
                        r_state <= S_POP;
                    end
                end
                S_FLUSH: begin
                    if (out_free) begin
                        r_on <= r_pend_n;
                        r_ol <= 1'b1;
                        r_os <= 1'b0;
                        r_pend_v <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
